// ===== rtl/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg
// shared constants, payload structs and helpers of the linear classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

    localparam int MAX_FEATURES = 32;
    localparam int MAX_CLASSES  = 8;

    // field widths
    localparam int ROW_W   = 6;
    localparam int CLS_W   = 3;
    localparam int NCLS_W  = 4;
    localparam int WGT_W   = 16;
    localparam int FEAT_W  = 16;
    localparam int SCORE_W = 40;
    localparam int PROD_W  = FEAT_W + WGT_W + 1;
    localparam int SUM_W   = SCORE_W + 1;

    // weight store geometry, bias row follows the feature rows
    localparam int DEPTH  = (MAX_FEATURES + 1) * MAX_CLASSES;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_NUM_CLASSES  = 1'b0;
    localparam logic REG_NUM_FEATURES = 1'b1;

    localparam logic OP_WEIGHT  = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef struct packed {
        logic                    operation;
        logic [ROW_W-1:0]        weight_row;
        logic [CLS_W-1:0]        class_index;
        logic signed [WGT_W-1:0] weight_value;
        logic [FEAT_W-1:0]       feature_value;
    } t_in_item;

    typedef struct packed {
        logic [CLS_W-1:0]          predicted_class;
        logic signed [SCORE_W-1:0] best_score;
    } t_out_item;

    // effective configuration
    typedef struct packed {
        logic [CLS_W-1:0] last_cls;
        logic [ROW_W-1:0] nfeat;
    } t_cfg;

    // one class step for the multiply-accumulate pipe
    typedef struct packed {
        logic              issue;
        logic              first;
        logic [CLS_W-1:0]  cls;
        logic [FEAT_W-1:0] feat;
    } t_mac_cmd;

    typedef struct packed {
        logic                      busy;
        logic [CLS_W-1:0]          best_cls;
        logic signed [SCORE_W-1:0] best_score;
    } t_mac_stat;

    function automatic logic [ADDR_W-1:0] f_waddr(input logic [ROW_W-1:0] row,
                                                   input logic [CLS_W-1:0] cls);
        return ADDR_W'(row) * ADDR_W'(MAX_CLASSES) + ADDR_W'(cls);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lca_cfg.sv =====
// ----------------------------------------------------------------------------
// lca_cfg
// apb register file for class and feature counts, with range clamping
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lca_cfg import lca_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [NCLS_W-1:0] r_num_classes;
    logic [ROW_W-1:0]  r_num_features;
    logic              w_wr;
    logic              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes  <= NCLS_W'(MAX_CLASSES);
            r_num_features <= ROW_W'(MAX_FEATURES);
        end else if (w_wr) begin
            case (w_idx)
                REG_NUM_CLASSES:  r_num_classes  <= pwdata[NCLS_W-1:0];
                REG_NUM_FEATURES: r_num_features <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NUM_CLASSES:  prdata = PDATA_W'(r_num_classes);
            REG_NUM_FEATURES: prdata = PDATA_W'(r_num_features);
            default:          prdata = '0;
        endcase
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_num_classes == '0) begin
            o_cfg.last_cls = '0;
        end else if (r_num_classes > NCLS_W'(MAX_CLASSES)) begin
            o_cfg.last_cls = CLS_W'(MAX_CLASSES - 1);
        end else begin
            o_cfg.last_cls = CLS_W'(r_num_classes - NCLS_W'(1));
        end
        if (r_num_features == '0) begin
            o_cfg.nfeat = ROW_W'(1);
        end else if (r_num_features > ROW_W'(MAX_FEATURES)) begin
            o_cfg.nfeat = ROW_W'(MAX_FEATURES);
        end else begin
            o_cfg.nfeat = r_num_features;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lca_wstore.sv =====
// ----------------------------------------------------------------------------
// lca_wstore
// weight and bias memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lca_wstore import lca_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_wr_en,
    input  wire logic [ADDR_W-1:0]       i_wr_addr,
    input  wire logic signed [WGT_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]       i_rd_addr_a,
    input  wire logic [ADDR_W-1:0]       i_rd_addr_b,
    output logic signed [WGT_W-1:0]      o_rd_data_a,
    output logic signed [WGT_W-1:0]      o_rd_data_b
);

    logic signed [WGT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/lca_mac.sv =====
// ----------------------------------------------------------------------------
// lca_mac
// score memory with a shared multiply, saturating accumulate and running
// arg-max over the classes of one feature
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lca_mac import lca_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_mac_cmd                i_cmd,
    input  wire logic signed [WGT_W-1:0] i_wgt,
    input  wire logic signed [WGT_W-1:0] i_bias,
    output t_mac_stat                    o_stat
);

    logic signed [SCORE_W-1:0] r_smem [MAX_CLASSES];
    logic [MAX_CLASSES-1:0]    r_svalid;

    // stage 1: memory data
    logic                      r_s1_vld;
    logic                      r_s1_first;
    logic [CLS_W-1:0]          r_s1_cls;
    logic [FEAT_W-1:0]         r_s1_feat;
    logic signed [SCORE_W-1:0] r_s1_score;
    logic                      r_s1_sval;

    // stage 2: product and start value
    logic                      r_s2_vld;
    logic [CLS_W-1:0]          r_s2_cls;
    logic signed [SCORE_W-1:0] r_s2_base;
    logic signed [PROD_W-1:0]  r_s2_prod;

    logic signed [SCORE_W-1:0] r_best;
    logic [CLS_W-1:0]          r_best_cls;

    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SCORE_W-1:0] w_base;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SCORE_W-1:0] w_sat;

    assign w_prod = PROD_W'($signed({1'b0, r_s1_feat})) * PROD_W'(i_wgt);

    always_comb begin
        if (r_s1_first) begin
            w_base = SCORE_W'($signed({i_bias, 16'h0000}));
        end else if (r_s1_sval) begin
            w_base = r_s1_score;
        end else begin
            w_base = '0;
        end
    end

    assign w_sum = SUM_W'(r_s2_base) + SUM_W'(r_s2_prod);

    always_comb begin
        if (w_sum[SUM_W-1] != w_sum[SUM_W-2]) begin
            w_sat = w_sum[SUM_W-1] ? SCORE_MIN : SCORE_MAX;
        end else begin
            w_sat = w_sum[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_svalid <= '0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld) begin
                r_svalid[r_s2_cls] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_cls   <= i_cmd.cls;
        r_s1_feat  <= i_cmd.feat;
        r_s1_score <= r_smem[i_cmd.cls];
        r_s1_sval  <= r_svalid[i_cmd.cls];
        r_s2_cls   <= r_s1_cls;
        r_s2_base  <= w_base;
        r_s2_prod  <= w_prod;
        if (r_s2_vld) begin
            r_smem[r_s2_cls] <= w_sat;
        end
    end

    // ties keep the lower index
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && (r_s2_cls == '0 || w_sat > r_best)) begin
            r_best     <= w_sat;
            r_best_cls <= r_s2_cls;
        end
    end

    assign o_stat.busy       = r_s1_vld | r_s2_vld;
    assign o_stat.best_cls   = r_best_cls;
    assign o_stat.best_score = r_best;

endmodule

`default_nettype wire

// ===== rtl/linear_classifier_argmax.sv =====
// ----------------------------------------------------------------------------
// linear_classifier_argmax
// linear multi-class classifier with arg-max over the class scores
// weight: one transfer a cycle while idle; feature: the input stalls while
// its classes go one class a cycle through the weight memory and the shared
// multiply-accumulate, then the pipe drains
// last feature of a row: an emit state then loads the output register,
// and waits while the output register is still held
// reset clears control state and marks stored scores invalid; weight
// store undefined until written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_classifier_argmax import lca_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_fcnt, n_fcnt;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [FEAT_W-1:0] r_feat, n_feat;
    logic              r_first, n_first;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_cfg              w_cfg;
    t_mac_cmd          w_cmd;
    t_mac_stat         w_stat;
    logic              w_in_acc;
    logic              w_wr_en;
    logic [ROW_W-1:0]  w_cnt;
    logic [ROW_W-1:0]  w_cnt_inc;
    logic signed [WGT_W-1:0] w_wgt;
    logic signed [WGT_W-1:0] w_bias;

    lca_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_wr_en    = w_in_acc && (i_in_data.operation == OP_WEIGHT)
                        && (i_in_data.weight_row <= ROW_W'(MAX_FEATURES));

    lca_wstore u_wstore (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (f_waddr(i_in_data.weight_row, i_in_data.class_index)),
        .i_wr_data   (i_in_data.weight_value),
        .i_rd_addr_a (f_waddr(r_row, r_cls)),
        .i_rd_addr_b (f_waddr(ROW_W'(MAX_FEATURES), r_cls)),
        .o_rd_data_a (w_wgt),
        .o_rd_data_b (w_bias)
    );

    assign w_cmd.issue = (r_state == ST_ISSUE);
    assign w_cmd.first = r_first;
    assign w_cmd.cls   = r_cls;
    assign w_cmd.feat  = r_feat;

    lca_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_wgt   (w_wgt),
        .i_bias  (w_bias),
        .o_stat  (w_stat)
    );

    // position of this feature in its row
    assign w_cnt     = (r_fcnt >= w_cfg.nfeat) ? '0 : r_fcnt;
    assign w_cnt_inc = w_cnt + ROW_W'(1);

    always_comb begin
        n_state     = r_state;
        n_fcnt      = r_fcnt;
        n_cls       = r_cls;
        n_row       = r_row;
        n_feat      = r_feat;
        n_first     = r_first;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_in_data.operation == OP_FEATURE) begin
                    n_state = ST_ISSUE;
                    n_cls   = '0;
                    n_row   = w_cnt;
                    n_feat  = i_in_data.feature_value;
                    n_first = (w_cnt == '0);
                    n_last  = (w_cnt_inc >= w_cfg.nfeat);
                    n_fcnt  = (w_cnt_inc >= w_cfg.nfeat) ? '0 : w_cnt_inc;
                end
            end
            ST_ISSUE: begin
                if (r_cls == w_cfg.last_cls) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cls = r_cls + CLS_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!w_stat.busy) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.predicted_class = w_stat.best_cls;
                    n_out.best_score      = w_stat.best_score;
                    n_out_valid           = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fcnt      <= n_fcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_row   <= n_row;
        r_feat  <= n_feat;
        r_first <= n_first;
        r_last  <= n_last;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
